// File: rtl/mep_pkg.sv
// Shared constants for the escape-time pixel block: field widths,
// fixed-point format, register indexes and register reset values.
// No dependencies.
package mep_pkg;

   // Field widths and fixed-point format
   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 28;
   localparam int ITER_BITS  = 16;

   localparam int Z_W    = 32;               // c and z held as signed 32-bit
   localparam int STEP_W = 31;
   localparam int PROD_W = 2 * Z_W;          // magnitude products
   localparam int SQ_W   = PROD_W - FRAC_BITS;   // truncated square
   localparam int PM_W   = SQ_W + 1;         // 2*|a|*|b| after shift
   localparam int WIDE_W = SQ_W + 3;         // signed update sums
   localparam int MAP_W  = COORD_BITS + STEP_W;  // coord * step
   localparam int MAPS_W = MAP_W + 2;        // view_min + coord * step
   localparam int DIV_W  = ITER_BITS + 8;    // n * 255 and shifted limit

   // Stream payload widths, rounded up to bytes
   localparam int REQ_W = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_W = ((ITER_BITS + 24 + 7) / 8) * 8;

   // Register port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_VIEW_MIN   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_PIXEL_STEP = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_ITER   = 2'd2;

   localparam logic [Z_W-1:0]       VIEW_MIN_RST  = 32'hD28E_0B7B;
   localparam logic [STEP_W-1:0]    PIXEL_STEP_RST = 31'd1288490;
   localparam logic [ITER_BITS-1:0] MAX_ITER_RST  = ITER_BITS'(200);

   // Color constants
   localparam logic [7:0] DARK_LIMIT = 8'd20;

endpackage

// File: rtl/mandelbrot_escape_pixel.sv
// Escape-time pixel engine: maps a pixel to c, iterates z = z^2 + c,
// and turns the iteration count into an RGB color.
// Depends on mep_pkg.
//
// Usage:
//   req_* : one item per pixel, tdata = {pixel_y, pixel_x}. req_tready is
//           high only while the engine is idle.
//   rsp_* : one item per request, tdata = {blue, green, red, count}. The
//           result sits in an output register, so the engine takes the
//           next pixel while the previous result still waits.
//   csr_* : register writes, always ready; write only while idle.
// Steps: coordinate mapping; passes of the shared complex-square unit, n + 1
//   passes when |a| or |b| > 2 or the limit is reached and n + 2 passes when
//   a^2 + b^2 > 4, n being the count; restoring division to an 8-bit quotient
//   (skipped when the limit is reached); bit-serial 8-bit square root; then
//   the output register.
// Throughput: one pixel at a time; the next request is taken only once the
//   engine is back in idle.
// Reset: synchronous, clears the sequencer and the output valid and loads
//   the register defaults (view_min -2.84, step 0.0048, limit 200).
// Stall: a finished result waits in the engine until the output register
//   frees up; the next request is not taken before that result moves in.
module mandelbrot_escape_pixel import mep_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // pixel_x, pixel_y
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // iteration_count, red, green, blue
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MAP_Y, ST_MAP_C, ST_SQUARE, ST_UPDATE, ST_DIVIDE, ST_ROOT, ST_EMIT
   } state_type;

   localparam logic signed [WIDE_W-1:0] ESC_LIM  = WIDE_W'(64'd2 << FRAC_BITS);
   localparam logic signed [WIDE_W-1:0] ESC_LIMN = -ESC_LIM;
   localparam logic [SQ_W:0]            ESC_FOUR = (SQ_W + 1)'(64'd4 << FRAC_BITS);

   state_type               state_ff;
   logic [Z_W-1:0]          view_min_ff;
   logic [STEP_W-1:0]       pixel_step_ff;
   logic [ITER_BITS-1:0]    max_iter_ff;

   logic [COORD_BITS-1:0]   pix_y_ff;
   logic [MAP_W-1:0]        map_prod_ff;
   logic signed [Z_W-1:0]   ca_ff, cb_ff, za_ff, zb_ff;
   logic [SQ_W-1:0]         sqa_ff, sqb_ff;
   logic [PM_W-1:0]         pm_ff;
   logic                    pneg_ff;
   logic                    first_ff;
   logic [ITER_BITS-1:0]    n_ff;
   logic [DIV_W-1:0]        rem_ff, div_ff;
   logic [7:0]              quo_ff;
   logic [2:0]              step_ff;
   logic [7:0]              bright_ff;
   logic [15:0]             rad_ff;
   logic [7:0]              root_ff;

   logic                    rsp_valid_ff;
   logic [ITER_BITS-1:0]    rsp_count_ff;
   logic [7:0]              rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   // Saturate view_min + coord*step to the signed 32-bit range
   function automatic logic signed [Z_W-1:0] sat_map(input logic [Z_W-1:0] base,
                                                     input logic [MAP_W-1:0] prod);
      logic signed [MAPS_W-1:0] sum;
      logic [MAPS_W-Z_W:0]      hi;
      sum = $signed({{(MAPS_W-Z_W){base[Z_W-1]}}, base}) + $signed({2'b00, prod});
      hi  = sum[MAPS_W-1:Z_W-1];
      if (&hi || ~|hi)
         return sum[Z_W-1:0];
      else if (sum[MAPS_W-1])
         return {1'b1, {(Z_W-1){1'b0}}};
      else
         return {1'b0, {(Z_W-1){1'b1}}};
   endfunction

   function automatic logic [Z_W-1:0] mag(input logic signed [Z_W-1:0] v);
      return v[Z_W-1] ? (~v + 1'b1) : v;
   endfunction

   // red = bright^2 * 255 / 659, saturated; only 0 and 20..255 occur
   function automatic logic [7:0] red_of(input logic [7:0] b);
      logic [7:0] r;
      unique case (b)
         8'd20:   r = 8'd154;
         8'd21:   r = 8'd170;
         8'd22:   r = 8'd187;
         8'd23:   r = 8'd204;
         8'd24:   r = 8'd222;
         8'd25:   r = 8'd241;
         default: r = (b > 8'd25) ? 8'd255 : 8'd0;
      endcase
      return r;
   endfunction

   // Shared complex-square unit: |a|^2, |b|^2, |a|*|b|
   logic [Z_W-1:0]    mag_a, mag_b;
   logic [PROD_W-1:0] prod_aa, prod_bb, prod_ab;
   assign mag_a   = mag(za_ff);
   assign mag_b   = mag(zb_ff);
   assign prod_aa = PROD_W'(mag_a) * PROD_W'(mag_a);
   assign prod_bb = PROD_W'(mag_b) * PROD_W'(mag_b);
   assign prod_ab = PROD_W'(mag_a) * PROD_W'(mag_b);

   // Update step: new z, escape tests
   logic signed [WIDE_W-1:0] za_in, zb_in, pw;
   logic [SQ_W:0]            sq_sum;
   logic                     esc_sum, esc_mag;
   logic [ITER_BITS-1:0]     n_in;
   logic                     upd_done;
   logic [ITER_BITS-1:0]     upd_n;

   always_comb begin
      pw      = $signed({2'b00, pm_ff});
      za_in   = $signed({3'b000, sqa_ff}) - $signed({3'b000, sqb_ff})
              + $signed({{(WIDE_W-Z_W){ca_ff[Z_W-1]}}, ca_ff});
      zb_in   = (pneg_ff ? -pw : pw)
              + $signed({{(WIDE_W-Z_W){cb_ff[Z_W-1]}}, cb_ff});
      sq_sum  = {1'b0, sqa_ff} + {1'b0, sqb_ff};
      esc_sum = !first_ff && (sq_sum > ESC_FOUR);
      esc_mag = (za_in > ESC_LIM) || (za_in < ESC_LIMN)
             || (zb_in > ESC_LIM) || (zb_in < ESC_LIMN);
      n_in    = first_ff ? '0 : n_ff + 1'b1;
      priority if (esc_sum) begin
         upd_done = 1'b1;
         upd_n    = n_ff;
      end else if (n_in == max_iter_ff || esc_mag) begin
         upd_done = 1'b1;
         upd_n    = n_in;
      end else begin
         upd_done = 1'b0;
         upd_n    = n_in;
      end
   end

   // Divider and square-root steps
   logic       div_ge;
   logic [7:0] quo_in, bright_in, trial;
   logic [15:0] trial_sq;
   assign div_ge    = rem_ff >= div_ff;
   assign quo_in    = {quo_ff[6:0], div_ge};
   assign bright_in = (quo_in < DARK_LIMIT) ? 8'd0 : quo_in;
   assign trial     = root_ff | (8'd1 << step_ff);
   assign trial_sq  = 16'(trial) * 16'(trial);

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_blue_ff, rsp_green_ff, rsp_red_ff, rsp_count_ff});

   // Sequencer, datapath registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         view_min_ff   <= VIEW_MIN_RST;
         pixel_step_ff <= PIXEL_STEP_RST;
         max_iter_ff   <= MAX_ITER_RST;
      end else begin
         // register writes
         if (csr_valid) begin
            unique case (csr_addr)
               REG_VIEW_MIN:   view_min_ff   <= csr_wdata[Z_W-1:0];
               REG_PIXEL_STEP: pixel_step_ff <= csr_wdata[STEP_W-1:0];
               REG_MAX_ITER:   max_iter_ff   <= csr_wdata[ITER_BITS-1:0];
               default: ;
            endcase
         end

         // output register empties; in EMIT a new item may take its place
         if (rsp_valid_ff && rsp_tready && state_ff != ST_EMIT)
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  map_prod_ff <= MAP_W'(req_tdata[COORD_BITS-1:0]) * MAP_W'(pixel_step_ff);
                  pix_y_ff    <= req_tdata[2*COORD_BITS-1:COORD_BITS];
                  state_ff    <= ST_MAP_Y;
               end
            end
            ST_MAP_Y: begin
               ca_ff       <= sat_map(view_min_ff, map_prod_ff);
               map_prod_ff <= MAP_W'(pix_y_ff) * MAP_W'(pixel_step_ff);
               state_ff    <= ST_MAP_C;
            end
            ST_MAP_C: begin
               cb_ff    <= sat_map(view_min_ff, map_prod_ff);
               zb_ff    <= sat_map(view_min_ff, map_prod_ff);
               za_ff    <= ca_ff;
               first_ff <= 1'b1;
               n_ff     <= '0;
               state_ff <= ST_SQUARE;
            end
            ST_SQUARE: begin
               sqa_ff   <= prod_aa[PROD_W-1:FRAC_BITS];
               sqb_ff   <= prod_bb[PROD_W-1:FRAC_BITS];
               pm_ff    <= prod_ab[PROD_W-1:FRAC_BITS-1];
               pneg_ff  <= za_ff[Z_W-1] ^ zb_ff[Z_W-1];
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               n_ff <= upd_n;
               if (upd_done) begin
                  step_ff <= 3'd7;
                  root_ff <= '0;
                  if (upd_n == max_iter_ff) begin
                     // never escaped (or zero limit): dark pixel
                     bright_ff <= '0;
                     rad_ff    <= '0;
                     state_ff  <= ST_ROOT;
                  end else begin
                     rem_ff   <= {upd_n, 8'd0} - DIV_W'(upd_n);
                     div_ff   <= DIV_W'({max_iter_ff, 7'd0});
                     quo_ff   <= '0;
                     state_ff <= ST_DIVIDE;
                  end
               end else begin
                  za_ff    <= za_in[Z_W-1:0];
                  zb_ff    <= zb_in[Z_W-1:0];
                  first_ff <= 1'b0;
                  state_ff <= ST_SQUARE;
               end
            end
            ST_DIVIDE: begin
               // one quotient bit of n*255 / limit per cycle;
               // step wraps from 0 to 7 for the root
               rem_ff  <= div_ge ? rem_ff - div_ff : rem_ff;
               quo_ff  <= quo_in;
               div_ff  <= div_ff >> 1;
               step_ff <= step_ff - 3'd1;
               if (step_ff == 3'd0) begin
                  bright_ff <= bright_in;
                  rad_ff    <= {bright_in, 8'd0} - 16'(bright_in);
                  root_ff   <= '0;
                  state_ff  <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               // one root bit of sqrt(255*bright) per cycle
               if (trial_sq <= rad_ff)
                  root_ff <= trial;
               step_ff <= step_ff - 3'd1;
               if (step_ff == 3'd0)
                  state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_count_ff <= n_ff;
                  rsp_red_ff   <= red_of(bright_ff);
                  rsp_green_ff <= bright_ff;
                  rsp_blue_ff  <= root_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// File: bench/mandelbrot_escape_pixel_tb.sv
// Self-checking bench for mandelbrot_escape_pixel: drives pixels and register writes,
// predicts iteration count and RGB color per pixel, and checks every result item.
// Depends on mep_pkg and the mandelbrot_escape_pixel RTL.
module mandelbrot_escape_pixel_tb import mep_pkg::*; ();

   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED = 2'd3;   // no register behind it
   localparam int  SETTLE_CYCLES = 64;
   localparam longint CYCLE_LIMIT = 5000000;

   // one result item, count in the low bits as on rsp_tdata
   typedef struct packed {
      logic [7:0]           blue;
      logic [7:0]           green;
      logic [7:0]           red;
      logic [ITER_BITS-1:0] count;
   } pixel_color_type;

   // Predicts the color of each accepted pixel and checks result items in order
   class escape_color_checker_type;
      logic [Z_W-1:0]       view_min;
      logic [STEP_W-1:0]    pixel_step;
      logic [ITER_BITS-1:0] iter_limit;
      pixel_color_type      pending_colors[$];
      int                   errors;

      function new();
         view_min   = VIEW_MIN_RST;
         pixel_step = PIXEL_STEP_RST;
         iter_limit = MAX_ITER_RST;
         errors     = 0;
      endfunction

      function void set_register(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_VIEW_MIN:   view_min   = data[Z_W-1:0];
            REG_PIXEL_STEP: pixel_step = data[STEP_W-1:0];
            REG_MAX_ITER:   iter_limit = data[ITER_BITS-1:0];
            default: ;
         endcase
      endfunction

      function bit [63:0] magnitude(bit [63:0] v);
         return v[63] ? 64'd0 - v : v;
      endfunction

      function bit [63:0] square_q(bit [63:0] v);
         bit [63:0] m;
         m = magnitude(v);
         return (m * m) >> FRAC_BITS;
      endfunction

      // pixel index to fixed point, saturated to signed 32 bits
      function bit [63:0] map_axis(logic [COORD_BITS-1:0] coord);
         longint base;
         longint c;
         base = longint'($signed(view_min));
         c = base + longint'(coord) * longint'(pixel_step);
         if (c > 64'sd2147483647) c = 64'sd2147483647;
         if (c < -64'sd2147483648) c = -64'sd2147483648;
         return 64'(c);
      endfunction

      function pixel_color_type escape_color(logic [COORD_BITS-1:0] px,
                                             logic [COORD_BITS-1:0] py);
         bit [63:0] ca, cb, za, zb, sqa, sqb, p, lim, four, n, bright, red, blue;
         int unsigned i;
         pixel_color_type res;
         ca = map_axis(px);
         cb = map_axis(py);
         za = ca;
         zb = cb;
         sqa = square_q(za);
         sqb = square_q(zb);
         lim = 64'd2 << FRAC_BITS;
         four = 64'd4 << FRAC_BITS;
         n = 0;
         // z = z^2 + c, count steps that stay inside radius 2
         for (i = 0; i < iter_limit; i++) begin
            p = (magnitude(za) * magnitude(zb)) >> (FRAC_BITS - 1);
            if (za[63] != zb[63]) p = 64'd0 - p;
            za = sqa - sqb + ca;
            zb = p + cb;
            if (magnitude(za) > lim || magnitude(zb) > lim) break;
            sqa = square_q(za);
            sqb = square_q(zb);
            if (sqa + sqb > four) break;
            n++;
         end
         // count to color; dark when never escaped or too dim
         bright = 0;
         if (iter_limit != 0) begin
            bright = n * 64'd255 / iter_limit;
            if (n == iter_limit || bright < DARK_LIMIT) bright = 0;
         end
         if (bright > 255) bright = 255;
         red = bright * bright * 64'd255 / 64'd659;
         if (red > 255) red = 255;
         blue = 0;
         while ((blue + 1) * (blue + 1) <= 64'd255 * bright) blue++;
         res.count = n[ITER_BITS-1:0];
         res.red   = red[7:0];
         res.green = bright[7:0];
         res.blue  = blue[7:0];
         return res;
      endfunction

      function void note_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
         pending_colors.push_back(escape_color(px, py));
      endfunction

      function void check_color(logic [RSP_W-1:0] data);
         pixel_color_type got, want;
         got = data[$bits(pixel_color_type)-1:0];
         if (pending_colors.size() == 0) begin
            $error("result item with no pixel pending: count %0d", got.count);
            errors++;
            return;
         end
         want = pending_colors.pop_front();
         if (got.count != want.count) begin
            $error("iteration_count: expected %0d, got %0d", want.count, got.count);
            errors++;
         end
         if (got.red != want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            errors++;
         end
         if (got.green != want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            errors++;
         end
         if (got.blue != want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;     // pixel_x, pixel_y
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;          // iteration_count, red, green, blue
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int     send_idle_pct = 0;
   int     stall_pct = 0;
   longint cycles = 0;

   escape_color_checker_type board = new();

   mandelbrot_escape_pixel uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("mandelbrot_escape_pixel: mismatch");
         $finish;
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // watch all three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.set_register(csr_addr, csr_wdata);
         if (req_tvalid && req_tready)
            board.note_pixel(req_tdata[COORD_BITS-1:0], req_tdata[2*COORD_BITS-1:COORD_BITS]);
         if (rsp_tvalid && rsp_tready) board.check_color(rsp_tdata);
      end
   end

   task automatic pick_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 61; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 61; end
         default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
   endtask

   // valid stays high between back-to-back items
   task automatic send_pixel(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({py, px});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random_pixel();
      send_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom));
   endtask

   // wait until every pixel sent so far has its color back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending_colors.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic setup_view(input logic [CSR_DATA_W-1:0] vmin, input logic [CSR_DATA_W-1:0] step,
                             input logic [CSR_DATA_W-1:0] limit);
      write_reg(REG_VIEW_MIN, vmin);
      write_reg(REG_PIXEL_STEP, step);
      write_reg(REG_MAX_ITER, limit);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] vmin, step, limit;
      int b, k, pick;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset view: corners and a point just inside the set
      pick_idling(0);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(0, 4095);
      send_pixel(4095, 0);
      send_pixel(590, 590);
      drain_results();

      // limit of one, unit step: inside, on the radius, outside
      setup_view(32'd0, 32'h1000_0000, 32'd1);
      send_pixel(0, 0);
      send_pixel(1, 0);
      send_pixel(2, 2);
      drain_results();

      // zero limit gives black and count 0
      setup_view(32'hE000_0000, 32'h0004_0000, 32'd0);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      drain_results();

      // mapping saturates high; bits above register widths dropped
      setup_view(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_0010);
      send_pixel(4095, 4095);
      send_pixel(0, 0);
      send_pixel(1, 4095);
      drain_results();

      // most negative view, zero step, write to unmapped index ignored
      setup_view(32'h8000_0000, 32'd0, 32'hABCD_0020);
      write_reg(REG_UNUSED, $urandom);
      send_pixel(0, 0);
      send_pixel(4095, 0);
      drain_results();

      // largest limit: one pixel never escapes
      setup_view(32'd0, 32'h0010_0000, 32'h0000_FFFF);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(100, 0);
      drain_results();

      // random views, 25 pixels each, idling pattern rotating per view
      for (b = 0; b < 44; b++) begin
         pick = $urandom_range(9);
         if (pick <= 5) begin
            vmin  = -$urandom_range(805306368, 268435456);
            step  = $urandom_range(300000, 100000);
            limit = $urandom_range(64, 1);
         end else if (pick <= 7) begin
            vmin  = -$urandom_range(570425344, 0);
            step  = $urandom_range(4000, 0);
            limit = $urandom_range(300, 16);
         end else if (pick == 8) begin
            vmin  = $urandom;
            step  = $urandom;
            limit = $urandom_range(40, 0);
         end else begin
            case ($urandom_range(2))
               0: vmin = 32'h8000_0000;
               1: vmin = 32'h7FFF_FFFF;
               default: vmin = 32'd0;
            endcase
            step  = $urandom_range(1) ? 32'h7FFF_FFFF : 32'd0;
            limit = $urandom_range(64, 1);
         end
         limit[CSR_DATA_W-1:ITER_BITS] = (CSR_DATA_W-ITER_BITS)'($urandom);
         setup_view(vmin, step, limit);
         if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom);
         pick_idling(b % 4);
         for (k = 0; k < 25; k++) send_random_pixel();
         drain_results();
      end

      pick_idling(0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending_colors.size() == 0) begin
         $display("mandelbrot_escape_pixel: match");
      end else begin
         $display("mandelbrot_escape_pixel: mismatch");
      end
      $finish;
   end

endmodule
